### sv/olist_pkg.sv
// Shared types and codes of the ordered list engine.
package olist_pkg;

  typedef enum logic [1:0] {
    OP_INS_END   = 2'd0,
    OP_INS_FRONT = 2'd1,
    OP_DELETE    = 2'd2,
    OP_DUMP      = 2'd3
  } olist_op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_FULL      = 2'd3
  } olist_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic          latch_in;
    logic          rd_en;
    logic          rd_next;
    logic          wr_tail;
    logic          wr_front;
    logic          wr_shift;
    logic          occ_inc;
    logic          occ_dec;
    logic          head_dec;
    logic          idx_clr;
    logic          idx_inc;
    logic          out_load;
    logic          out_dump;
    olist_status_t out_status;
  } olist_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    olist_op_t op;
    logic      full;
    logic      empty;
    logic      match;
    logic      idx_last;
    logic      idx_penult;
    logic      out_free;
  } olist_sts_t;

endpackage

### sv/olist_ctrl.sv
// Controller state machine of the ordered list engine.
module olist_ctrl (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  olist_pkg::olist_sts_t  sts,
  output olist_pkg::olist_cmd_t  cmd
);

  typedef enum logic [8:0] {
    S_IDLE     = 9'b000000001,
    S_DISPATCH = 9'b000000010,
    S_SCAN_RD  = 9'b000000100,
    S_SCAN_CMP = 9'b000001000,
    S_SH_RD    = 9'b000010000,
    S_SH_WR    = 9'b000100000,
    S_RESP     = 9'b001000000,
    S_DUMP_RD  = 9'b010000000,
    S_DUMP_OUT = 9'b100000000
  } state_t;

  state_t                    state_r, state_nxt;
  olist_pkg::olist_status_t  resp_r, resp_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    resp_nxt       = resp_r;
    cmd            = '0;
    cmd.out_status = olist_pkg::ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch_in = 1'b1;
          state_nxt    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        cmd.idx_clr = 1'b1;
        state_nxt   = S_RESP;
        unique case (sts.op) inside
          olist_pkg::OP_INS_END, olist_pkg::OP_INS_FRONT: begin
            if (sts.full) begin
              resp_nxt = olist_pkg::ST_FULL;
            end else begin
              resp_nxt    = olist_pkg::ST_OK;
              cmd.occ_inc = 1'b1;
              if (sts.op == olist_pkg::OP_INS_END) begin
                cmd.wr_tail = 1'b1;
              end else begin
                cmd.wr_front = 1'b1;
                cmd.head_dec = 1'b1;
              end
            end
          end
          olist_pkg::OP_DELETE: begin
            if (sts.empty) begin
              resp_nxt = olist_pkg::ST_EMPTY;
            end else begin
              state_nxt = S_SCAN_RD;
            end
          end
          default: begin
            if (sts.empty) begin
              resp_nxt = olist_pkg::ST_EMPTY;
            end else begin
              state_nxt = S_DUMP_RD;
            end
          end
        endcase
      end
      S_SCAN_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (sts.match) begin
          if (sts.idx_last) begin
            cmd.occ_dec = 1'b1;
            resp_nxt    = olist_pkg::ST_OK;
            state_nxt   = S_RESP;
          end else begin
            state_nxt = S_SH_RD;
          end
        end else if (sts.idx_last) begin
          resp_nxt  = olist_pkg::ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else begin
          cmd.idx_inc = 1'b1;
          state_nxt   = S_SCAN_RD;
        end
      end
      S_SH_RD: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_next = 1'b1;
        state_nxt   = S_SH_WR;
      end
      S_SH_WR: begin
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (sts.idx_penult) begin
          cmd.occ_dec = 1'b1;
          resp_nxt    = olist_pkg::ST_OK;
          state_nxt   = S_RESP;
        end else begin
          state_nxt = S_SH_RD;
        end
      end
      S_RESP: begin
        if (sts.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_status = resp_r;
          state_nxt      = S_IDLE;
        end
      end
      S_DUMP_RD: begin
        cmd.rd_en = 1'b1;
        state_nxt = S_DUMP_OUT;
      end
      S_DUMP_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_dump = 1'b1;
          cmd.idx_inc  = 1'b1;
          state_nxt    = sts.idx_last ? S_IDLE : S_DUMP_RD;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      resp_r  <= olist_pkg::ST_OK;
    end else begin
      state_r <= state_nxt;
      resp_r  <= resp_nxt;
    end
  end

endmodule

### sv/olist_dp.sv
// Datapath of the ordered list engine: entry memory, ring pointers and result register.
module olist_dp #(
  parameter int DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [1:0]             in_tuser,
  input  logic [31:0]            in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [31:0]            out_tdata,
  output logic [1:0]             out_tuser,
  output logic                   out_tlast,
  input  olist_pkg::olist_cmd_t  cmd,
  output olist_pkg::olist_sts_t  sts
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = IDX_W + 1;

  logic [31:0]              mem [DEPTH];
  logic [31:0]              rd_data_r;
  logic [31:0]              value_r;
  olist_pkg::olist_op_t     op_r;
  logic [IDX_W-1:0]         head_r, head_nxt;
  logic [CNT_W-1:0]         occ_r, occ_nxt;
  logic [IDX_W-1:0]         idx_r, idx_nxt;
  logic                     out_valid_r;
  olist_pkg::olist_status_t out_status_r;
  logic [31:0]              out_elem_r;
  logic                     out_last_r;

  logic [IDX_W-1:0]         head_dec_val;
  logic [IDX_W-1:0]         rd_addr;
  logic [IDX_W-1:0]         wr_addr;
  logic [31:0]              wr_data;
  logic                     wr_en;

  // Head plus an offset, folded back into the ring by one subtract.
  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [SUM_W-1:0] off);
    logic [SUM_W-1:0] s;
    s = SUM_W'(base) + off;
    if (s >= SUM_W'(DEPTH)) s = s - SUM_W'(DEPTH);
    return s[IDX_W-1:0];
  endfunction

  assign head_dec_val = (head_r == '0) ? IDX_W'(DEPTH - 1) : head_r - IDX_W'(1);

  assign rd_addr = ring_pos(head_r, SUM_W'(idx_r) + (cmd.rd_next ? SUM_W'(1) : SUM_W'(0)));

  always_comb begin
    wr_en   = cmd.wr_tail | cmd.wr_front | cmd.wr_shift;
    wr_data = value_r;
    wr_addr = ring_pos(head_r, SUM_W'(idx_r));
    if (cmd.wr_tail) begin
      wr_addr = ring_pos(head_r, SUM_W'(occ_r));
    end else if (cmd.wr_front) begin
      wr_addr = head_dec_val;
    end else begin
      wr_data = rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      op_r    <= olist_pkg::olist_op_t'(in_tuser);
      value_r <= in_tdata;
    end
  end

  always_comb begin
    head_nxt = head_r;
    occ_nxt  = occ_r;
    idx_nxt  = idx_r;
    if (cmd.head_dec) head_nxt = head_dec_val;
    if (cmd.occ_inc)  occ_nxt  = occ_r + CNT_W'(1);
    if (cmd.occ_dec)  occ_nxt  = occ_r - CNT_W'(1);
    if (cmd.idx_clr)  idx_nxt  = '0;
    if (cmd.idx_inc)  idx_nxt  = idx_r + IDX_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      occ_r  <= '0;
    end else begin
      head_r <= head_nxt;
      occ_r  <= occ_nxt;
    end
    idx_r <= idx_nxt;
  end

  always_comb begin
    sts.op         = op_r;
    sts.full       = (occ_r == CNT_W'(DEPTH));
    sts.empty      = (occ_r == '0);
    sts.match      = (rd_data_r == value_r);
    sts.idx_last   = (SUM_W'(idx_r) + SUM_W'(1) == SUM_W'(occ_r));
    sts.idx_penult = (SUM_W'(idx_r) + SUM_W'(2) == SUM_W'(occ_r));
    sts.out_free   = !out_valid_r || out_tready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
    if (cmd.out_load) begin
      out_status_r <= cmd.out_status;
      out_elem_r   <= cmd.out_dump ? rd_data_r : 32'd0;
      out_last_r   <= cmd.out_dump ? sts.idx_last : 1'b1;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_elem_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

### sv/ordered_list_engine.sv
// Top level of the ordered list engine: a double-ended list kept as a ring in memory.
//
// Commands arrive on the in_ stream: in_tuser carries the operation (insert at the
// tail, insert at the head, delete the first entry equal to a value, dump the list)
// and in_tdata the signed 32-bit value. Results leave on the out_ stream: out_tuser
// carries the status, out_tdata the element (zero unless dumping) and out_tlast
// marks the final result of a command.
// A command is taken only while the controller is idle; one command is worked on at
// a time, but a new command may be taken while the last result still waits in the
// output register. An insert, or any command on an empty list, goes from dispatch
// straight to the result state. A dump reads each element through the registered
// memory port before it is presented. A delete reads and compares entries up to the
// match, then moves each later entry one place towards the head to close the gap.
// Reset empties the list at once (head and count cleared); no clearing pass is run.
// When the receiver stalls, the result is held in the output register and the
// controller waits before loading the next one, so nothing is lost.
module ordered_list_engine #(
  parameter int DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic [1:0]  in_tuser,   // [1:0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] element
  output logic [1:0]  out_tuser,  // [1:0] status
  output logic        out_tlast
);

  olist_pkg::olist_cmd_t cmd;
  olist_pkg::olist_sts_t sts;

  // The controller sequences each command; the datapath holds the list and the result.
  olist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  olist_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd        (cmd),
    .sts        (sts)
  );

  // A result is never loaded over one that the receiver has not yet taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result register overwritten before transfer");

  // The input is latched exactly on a transfer.
  a_latch_on_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.latch_in == (in_tvalid && in_tready))
    else $error("input latched outside a transfer");

  // No insert is written into a full list.
  a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.wr_tail || cmd.wr_front) |-> !sts.full)
    else $error("insert written into a full list");

  // At most one memory write source is active.
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.wr_tail, cmd.wr_front, cmd.wr_shift}) <= 1)
    else $error("conflicting memory writes");

  // The count is only lowered while the list holds entries.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.occ_dec |-> !sts.empty)
    else $error("occupancy decremented on an empty list");

endmodule
